>>> hw/rtl/mec_pkg.sv
// ----------------------------------------------------------------------------
// mec_pkg: shared types, sizes and helpers for the mesh equality checker
// Holds the storage sizes, operation codes and the coordinate and face-key
// arithmetic.
// ----------------------------------------------------------------------------
package mec_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int MAX_FACES  = 2048;
  localparam int COORD_BITS = 32;

  localparam int PIDX_W = $clog2(MAX_POINTS);
  localparam int PCNT_W = PIDX_W + 1;
  localparam int FIDX_W = $clog2(MAX_FACES);
  localparam int FCNT_W = FIDX_W + 1;
  localparam int CRN_W  = 10;
  localparam int KEY_W  = 3 * CRN_W;
  localparam int TOL_W  = 31;

  typedef enum logic [2:0] {
    OP_POINT_A = 3'd0,
    OP_POINT_B = 3'd1,
    OP_FACE_A  = 3'd2,
    OP_FACE_B  = 3'd3,
    OP_COMPARE = 3'd4
  } op_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef logic [KEY_W-1:0] key_t;

  // |a - b| < tol on one coordinate
  function automatic logic coord_near(coord_t a, coord_t b, logic [TOL_W-1:0] tol);
    logic signed [COORD_BITS:0] d;
    logic [COORD_BITS:0] mag;
    d   = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    mag = d[COORD_BITS] ? (~d + 1'b1) : d;
    return mag < (COORD_BITS+1)'(tol);
  endfunction

  function automatic logic pt_near(point_t a, point_t b, logic [TOL_W-1:0] tol);
    return coord_near(a.x, b.x, tol) && coord_near(a.y, b.y, tol) &&
           coord_near(a.z, b.z, tol);
  endfunction

  // strict lexicographic order on (x, y, z)
  function automatic logic pt_lt(point_t a, point_t b);
    logic r;
    if (a.x != b.x) r = a.x < b.x;
    else if (a.y != b.y) r = a.y < b.y;
    else r = a.z < b.z;
    return r;
  endfunction

  // smallest rotation of a renamed face
  function automatic key_t rot_min(logic [CRN_W-1:0] a, logic [CRN_W-1:0] b,
                                   logic [CRN_W-1:0] c);
    key_t k0, k1, k2, m;
    k0 = {a, b, c};
    k1 = {b, c, a};
    k2 = {c, a, b};
    m  = (k0 < k1) ? k0 : k1;
    return (m < k2) ? m : k2;
  endfunction

endpackage

>>> hw/rtl/mesh_equality_check_core.sv
// ----------------------------------------------------------------------------
// mesh_equality_check_core: compares two triangle meshes within a tolerance
// Load requests append points and faces; a compare request walks the stores,
// ranks points unless they match by index, sorts face keys, and reports one result.
// ----------------------------------------------------------------------------
// Loads stream at one per cycle while no compare is running (busy is low).
// A compare sweeps the point and face memories entry by entry; it skips the
// point ranking when points match by index, and otherwise ranks both point sets.
// The result strobe is high for one cycle; the receiver cannot stall it.
// Reset clears counts, overflow flag and sets tolerance to 1; stores keep data.
module mesh_equality_check_core
  import mec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            operation,
  input  logic signed [31:0]    coord_x,
  input  logic signed [31:0]    coord_y,
  input  logic signed [31:0]    coord_z,
  input  logic [9:0]            corner_one,
  input  logic [9:0]            corner_two,
  input  logic [9:0]            corner_three,
  input  logic                  tolerance_we,
  input  logic [30:0]           tolerance_wdata,
  output logic                  done,
  output logic                  meshes_differ,
  output logic                  capacity_exceeded
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_IDX, S_RK_PI, S_RK_CAP, S_RK_SW, S_PAIR,
    S_FC_RD, S_FC_CAP, S_FC_R1, S_FC_R2, S_FC_R3, S_FC_WR,
    S_KS_PI, S_KS_CAP, S_KS_SW, S_KCMP, S_DONE
  } state_t;

  state_t state;

  logic [TOL_W-1:0]  tolerance;
  logic [PCNT_W-1:0] pcnt [2];
  logic [FCNT_W-1:0] fcnt [2];
  logic              ovf;
  logic              side;
  logic              ident;
  logic              differ;
  logic [FCNT_W-1:0] idx_i;
  logic [FCNT_W-1:0] idx_j;
  logic [FCNT_W-1:0] tag1;
  logic              vld1;
  logic              vld2;
  logic [FIDX_W-1:0] cnt;
  point_t            piv;
  key_t              ki;
  logic [CRN_W-1:0]  c1, c2;
  logic [CRN_W-1:0]  r0, r1, r2;

  // memories
  point_t            pts_mem [2][MAX_POINTS];
  key_t              fc_mem  [2][MAX_FACES];
  logic [PIDX_W-1:0] rk_mem  [2][MAX_POINTS];
  logic [PIDX_W-1:0] ord_mem [2][MAX_POINTS];
  key_t              srt_mem [2][MAX_FACES];

  logic              pt_we    [2];
  logic [PIDX_W-1:0] pt_raddr [2];
  point_t            pt_rdata [2];
  point_t            pt_wdata;
  logic              fc_we    [2];
  logic [FIDX_W-1:0] fc_waddr [2];
  key_t              fc_wdata [2];
  logic [FIDX_W-1:0] fc_raddr;
  key_t              fc_rdata [2];
  logic              rk_we    [2];
  logic [PIDX_W-1:0] rk_raddr;
  logic [PIDX_W-1:0] rk_rdata [2];
  logic [PIDX_W-1:0] ord_rdata [2];
  logic              srt_we   [2];
  key_t              srt_rdata [2];

  logic              accept;
  logic [FCNT_W-1:0] lim;
  logic              issue;
  logic              sweep_end;
  logic              rk_less;
  logic              ks_less;
  key_t              key_new;
  key_t              cap_face;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign pt_wdata = '{x: coord_x, y: coord_y, z: coord_z};
  assign cap_face = fc_rdata[side];
  assign key_new  = rot_min(r0, r1, r2);

  always_comb begin
    case (state)
      S_IDX, S_RK_SW, S_PAIR: lim = FCNT_W'(pcnt[0]);
      default:                lim = fcnt[0];
    endcase
  end

  assign issue     = idx_j < lim;
  assign sweep_end = !issue && !vld1 && !vld2;
  assign rk_less   = pt_lt(pt_rdata[side], piv) ||
                     ((pt_rdata[side] == piv) && (tag1 < idx_i));
  assign ks_less   = (fc_rdata[side] < ki) ||
                     ((fc_rdata[side] == ki) && (tag1 < idx_i));

  always_comb begin
    fc_raddr = (state == S_KS_SW) ? idx_j[FIDX_W-1:0] : idx_i[FIDX_W-1:0];
    case (state)
      S_FC_CAP: rk_raddr = cap_face[KEY_W-1 -: CRN_W];
      S_FC_R1:  rk_raddr = c1;
      default:  rk_raddr = c2;
    endcase
    for (int s = 0; s < 2; s++) begin
      pt_we[s] = accept && (operation == OP_POINT_A + 3'(s)) &&
                 (pcnt[s] < PCNT_W'(MAX_POINTS));
      case (state)
        S_RK_PI: pt_raddr[s] = idx_i[PIDX_W-1:0];
        S_PAIR:  pt_raddr[s] = ord_rdata[s];
        default: pt_raddr[s] = idx_j[PIDX_W-1:0];
      endcase
      if (state == S_FC_WR) begin
        fc_we[s]    = (side == 1'(s));
        fc_waddr[s] = idx_i[FIDX_W-1:0];
        fc_wdata[s] = key_new;
      end else begin
        fc_we[s]    = accept && (operation == OP_FACE_A + 3'(s)) &&
                      (fcnt[s] < FCNT_W'(MAX_FACES));
        fc_waddr[s] = fcnt[s][FIDX_W-1:0];
        fc_wdata[s] = {corner_one, corner_two, corner_three};
      end
      rk_we[s]  = (state == S_RK_SW) && sweep_end && (side == 1'(s));
      srt_we[s] = (state == S_KS_SW) && sweep_end && (side == 1'(s));
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < 2; s++) begin
      if (pt_we[s]) pts_mem[s][pcnt[s][PIDX_W-1:0]] <= pt_wdata;
      pt_rdata[s] <= pts_mem[s][pt_raddr[s]];
      if (fc_we[s]) fc_mem[s][fc_waddr[s]] <= fc_wdata[s];
      fc_rdata[s] <= fc_mem[s][fc_raddr];
      if (rk_we[s]) rk_mem[s][idx_i[PIDX_W-1:0]] <= cnt[PIDX_W-1:0];
      rk_rdata[s] <= rk_mem[s][rk_raddr];
      if (rk_we[s]) ord_mem[s][cnt[PIDX_W-1:0]] <= idx_i[PIDX_W-1:0];
      ord_rdata[s] <= ord_mem[s][idx_j[PIDX_W-1:0]];
      if (srt_we[s]) srt_mem[s][cnt] <= ki;
      srt_rdata[s] <= srt_mem[s][idx_j[FIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      tolerance         <= TOL_W'(1);
      pcnt[0]           <= '0;
      pcnt[1]           <= '0;
      fcnt[0]           <= '0;
      fcnt[1]           <= '0;
      ovf               <= 1'b0;
      done              <= 1'b0;
      meshes_differ     <= 1'b0;
      capacity_exceeded <= 1'b0;
      side              <= 1'b0;
      ident             <= 1'b0;
      differ            <= 1'b0;
      idx_i             <= '0;
      idx_j             <= '0;
      vld1              <= 1'b0;
      vld2              <= 1'b0;
      cnt               <= '0;
    end else begin
      done <= 1'b0;
      if (tolerance_we) tolerance <= tolerance_wdata;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (operation)
              OP_POINT_A, OP_POINT_B: begin
                if (pt_we[operation[0]]) pcnt[operation[0]] <= pcnt[operation[0]] + 1'b1;
                else ovf <= 1'b1;
              end
              OP_FACE_A, OP_FACE_B: begin
                if (fc_we[operation[0]]) fcnt[operation[0]] <= fcnt[operation[0]] + 1'b1;
                else ovf <= 1'b1;
              end
              OP_COMPARE: begin
                differ <= 1'b0;
                ident  <= 1'b1;
                state  <= S_CHECK;
              end
              default: ;
            endcase
          end
        end
        S_CHECK: begin
          if (ovf || tolerance == '0 || pcnt[0] != pcnt[1] || fcnt[0] != fcnt[1]) begin
            differ <= 1'b1;
            state  <= S_DONE;
          end else begin
            idx_j <= '0;
            vld1  <= 1'b0;
            vld2  <= 1'b0;
            state <= S_IDX;
          end
        end
        S_IDX: begin
          if (issue) idx_j <= idx_j + 1'b1;
          vld1 <= issue;
          if (vld1 && !pt_near(pt_rdata[0], pt_rdata[1], tolerance)) ident <= 1'b0;
          if (sweep_end) begin
            side  <= 1'b0;
            idx_i <= '0;
            state <= ident ? S_FC_RD : S_RK_PI;
          end
        end
        S_RK_PI: begin
          if (idx_i < FCNT_W'(pcnt[0])) begin
            state <= S_RK_CAP;
          end else if (!side) begin
            side  <= 1'b1;
            idx_i <= '0;
          end else begin
            idx_j <= '0;
            vld1  <= 1'b0;
            vld2  <= 1'b0;
            state <= S_PAIR;
          end
        end
        S_RK_CAP: begin
          piv   <= pt_rdata[side];
          idx_j <= '0;
          cnt   <= '0;
          vld1  <= 1'b0;
          state <= S_RK_SW;
        end
        S_RK_SW: begin
          if (issue) idx_j <= idx_j + 1'b1;
          vld1 <= issue;
          tag1 <= idx_j;
          if (vld1 && rk_less) cnt <= cnt + 1'b1;
          if (sweep_end) begin
            idx_i <= idx_i + 1'b1;
            state <= S_RK_PI;
          end
        end
        S_PAIR: begin
          if (issue) idx_j <= idx_j + 1'b1;
          vld1 <= issue;
          vld2 <= vld1;
          if (vld2 && !pt_near(pt_rdata[0], pt_rdata[1], tolerance)) differ <= 1'b1;
          if (sweep_end) begin
            side  <= 1'b0;
            idx_i <= '0;
            state <= S_FC_RD;
          end
        end
        S_FC_RD: begin
          if (idx_i < fcnt[0]) begin
            state <= S_FC_CAP;
          end else if (!side) begin
            side  <= 1'b1;
            idx_i <= '0;
          end else begin
            side  <= 1'b0;
            idx_i <= '0;
            state <= S_KS_PI;
          end
        end
        S_FC_CAP: begin
          c1 <= cap_face[KEY_W-CRN_W-1 -: CRN_W];
          c2 <= cap_face[CRN_W-1:0];
          // flag any corner at or past the point count
          if ({1'b0, cap_face[KEY_W-1 -: CRN_W]} >= pcnt[0] ||
              {1'b0, cap_face[KEY_W-CRN_W-1 -: CRN_W]} >= pcnt[0] ||
              {1'b0, cap_face[CRN_W-1:0]} >= pcnt[0]) differ <= 1'b1;
          if (ident) begin
            r0    <= cap_face[KEY_W-1 -: CRN_W];
            r1    <= cap_face[KEY_W-CRN_W-1 -: CRN_W];
            r2    <= cap_face[CRN_W-1:0];
            state <= S_FC_WR;
          end else begin
            state <= S_FC_R1;
          end
        end
        S_FC_R1: begin
          r0    <= rk_rdata[side];
          state <= S_FC_R2;
        end
        S_FC_R2: begin
          r1    <= rk_rdata[side];
          state <= S_FC_R3;
        end
        S_FC_R3: begin
          r2    <= rk_rdata[side];
          state <= S_FC_WR;
        end
        S_FC_WR: begin
          idx_i <= idx_i + 1'b1;
          state <= S_FC_RD;
        end
        S_KS_PI: begin
          if (idx_i < fcnt[0]) begin
            state <= S_KS_CAP;
          end else if (!side) begin
            side  <= 1'b1;
            idx_i <= '0;
          end else begin
            idx_j <= '0;
            vld1  <= 1'b0;
            vld2  <= 1'b0;
            state <= S_KCMP;
          end
        end
        S_KS_CAP: begin
          ki    <= fc_rdata[side];
          idx_j <= '0;
          cnt   <= '0;
          vld1  <= 1'b0;
          state <= S_KS_SW;
        end
        S_KS_SW: begin
          if (issue) idx_j <= idx_j + 1'b1;
          vld1 <= issue;
          tag1 <= idx_j;
          if (vld1 && ks_less) cnt <= cnt + 1'b1;
          if (sweep_end) begin
            idx_i <= idx_i + 1'b1;
            state <= S_KS_PI;
          end
        end
        S_KCMP: begin
          if (issue) idx_j <= idx_j + 1'b1;
          vld1 <= issue;
          if (vld1 && srt_rdata[0] != srt_rdata[1]) differ <= 1'b1;
          if (sweep_end) state <= S_DONE;
        end
        S_DONE: begin
          done              <= 1'b1;
          meshes_differ     <= differ;
          capacity_exceeded <= ovf;
          pcnt[0]           <= '0;
          pcnt[1]           <= '0;
          fcnt[0]           <= '0;
          fcnt[1]           <= '0;
          ovf               <= 1'b0;
          state             <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
